// File: rtl/core/fsc_pkg.sv
// shared types, constants and lookup functions for the filename sanity checker
// depends on nothing; imported by every module of the block
package fsc_pkg;

  localparam int NUM_RESERVED = 22;
  localparam int POS_W        = 3;
  localparam logic [POS_W-1:0] POS_SAT = POS_W'(5);
  localparam logic [7:0] CHR_DOT   = 8'h2e;
  localparam logic [7:0] CHR_SLASH = 8'h2f;
  localparam logic [7:0] CTRL_MAX  = 8'd31;

  typedef enum logic [2:0] {
    RSN_OK        = 3'd0,
    RSN_DOT       = 3'd1,
    RSN_RESERVED  = 3'd2,
    RSN_SLASH     = 3'd3,
    RSN_FORBIDDEN = 3'd4
  } reason_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic    sane;
    reason_t reject_reason;
  } result_t;

  // reserved device names, one entry per name, unused tail bytes are zero
  localparam logic [7:0] RES_TEXT [NUM_RESERVED][4] = '{
    '{"C", "O", "N", 8'h00}, '{"P", "R", "N", 8'h00},
    '{"A", "U", "X", 8'h00}, '{"N", "U", "L", 8'h00},
    '{"C", "O", "M", "1"}, '{"C", "O", "M", "2"}, '{"C", "O", "M", "3"},
    '{"C", "O", "M", "4"}, '{"C", "O", "M", "5"}, '{"C", "O", "M", "6"},
    '{"C", "O", "M", "7"}, '{"C", "O", "M", "8"}, '{"C", "O", "M", "9"},
    '{"L", "P", "T", "1"}, '{"L", "P", "T", "2"}, '{"L", "P", "T", "3"},
    '{"L", "P", "T", "4"}, '{"L", "P", "T", "5"}, '{"L", "P", "T", "6"},
    '{"L", "P", "T", "7"}, '{"L", "P", "T", "8"}, '{"L", "P", "T", "9"}
  };

  function automatic logic [POS_W-1:0] res_len(input int idx);
    return (idx < 4) ? POS_W'(3) : POS_W'(4);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) ? (b - 8'd32) : b;
  endfunction

  function automatic logic is_forbidden(input logic [7:0] b);
    return (b <= CTRL_MAX) || (b == 8'h3c) || (b == 8'h3e) || (b == 8'h3a) ||
           (b == 8'h22) || (b == 8'h7c) || (b == 8'h3f) || (b == 8'h2a) ||
           (b == 8'h5c);
  endfunction

endpackage

// File: rtl/core/fsc_in_stage.sv
// input register of the filename sanity checker
// depends on fsc_pkg for the item type
module fsc_in_stage
  import fsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  pop,
  output logic  stage_valid,
  output item_t stage_item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready    = !valid_r || pop;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// File: rtl/core/fsc_name_scan.sv
// per-name match state and verdict logic of the filename sanity checker
// depends on fsc_pkg for types, reserved name table and byte classes
module fsc_name_scan
  import fsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    take,
  input  item_t   item,
  input  logic    os_checks,
  output result_t verdict
);

  logic [POS_W-1:0]        pos_r, pos_nxt, pos_upd;
  logic [NUM_RESERVED-1:0] mask_r, mask_nxt, mask_upd;
  logic [1:0]              rs_r, rs_nxt, rs_upd;
  logic [1:0]              dots_r, dots_nxt, dots_upd;
  logic                    slash_r, slash_nxt, slash_upd;
  logic                    bad_r, bad_nxt, bad_upd;
  logic                    dot_after;
  logic                    is_dot;
  logic                    hit;
  logic [7:0]              up;
  reason_t                 reason;

  always_comb begin
    is_dot    = item.char_byte == CHR_DOT;
    up        = to_upper(item.char_byte);
    dot_after = 1'b0;
    mask_upd  = mask_r;
    pos_upd   = pos_r;
    rs_upd    = rs_r;
    dots_upd  = dots_r;
    slash_upd = slash_r;
    bad_upd   = bad_r;
    if (item.has_byte) begin
      for (int i = 0; i < NUM_RESERVED; i++) begin
        if (mask_r[i]) begin
          if (pos_r < res_len(i)) begin
            if (up != RES_TEXT[i][pos_r[1:0]]) begin
              mask_upd[i] = 1'b0;
            end
          end else begin
            if (pos_r == res_len(i) && is_dot) begin
              dot_after = 1'b1;
            end
            mask_upd[i] = 1'b0;
          end
        end
      end
      if (rs_r == 2'd1 && is_dot) begin
        rs_upd = 2'd2;
      end
      if (dot_after) begin
        rs_upd = 2'd1;
      end
      if (is_dot && dots_r < 2'd2) begin
        dots_upd = dots_r + 2'd1;
      end else begin
        dots_upd = 2'd3;
      end
      if (item.char_byte == CHR_SLASH) begin
        slash_upd = 1'b1;
      end else if (is_forbidden(item.char_byte) && !slash_r) begin
        bad_upd = 1'b1;
      end
      pos_upd = (pos_r < POS_SAT) ? pos_r + POS_W'(1) : POS_SAT;
    end
  end

  always_comb begin
    hit = rs_upd == 2'd1;
    for (int i = 0; i < NUM_RESERVED; i++) begin
      if (mask_upd[i] && res_len(i) == pos_upd) begin
        hit = 1'b1;
      end
    end
    if (dots_upd == 2'd1 || dots_upd == 2'd2) begin
      reason = RSN_DOT;
    end else if (os_checks && hit) begin
      reason = RSN_RESERVED;
    end else if (os_checks && bad_upd) begin
      reason = RSN_FORBIDDEN;
    end else if (slash_upd) begin
      reason = RSN_SLASH;
    end else begin
      reason = RSN_OK;
    end
    verdict.reject_reason = reason;
    verdict.sane          = reason == RSN_OK;
  end

  always_comb begin
    pos_nxt   = pos_r;
    mask_nxt  = mask_r;
    rs_nxt    = rs_r;
    dots_nxt  = dots_r;
    slash_nxt = slash_r;
    bad_nxt   = bad_r;
    if (take) begin
      if (item.last) begin
        pos_nxt   = '0;
        mask_nxt  = '1;
        rs_nxt    = 2'd0;
        dots_nxt  = 2'd0;
        slash_nxt = 1'b0;
        bad_nxt   = 1'b0;
      end else begin
        pos_nxt   = pos_upd;
        mask_nxt  = mask_upd;
        rs_nxt    = rs_upd;
        dots_nxt  = dots_upd;
        slash_nxt = slash_upd;
        bad_nxt   = bad_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      mask_r  <= '1;
      rs_r    <= 2'd0;
      dots_r  <= 2'd0;
      slash_r <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      mask_r  <= mask_nxt;
      rs_r    <= rs_nxt;
      dots_r  <= dots_nxt;
      slash_r <= slash_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// File: rtl/core/filename_sanity_checker.sv
// top level of the filename sanity checker: input register, name scan, result register
// depends on fsc_pkg, fsc_in_stage and fsc_name_scan
//
// The block takes one byte of a file name per item and accepts a new item every
// cycle unless a result waiting on out_tready holds a last item. After its last
// item is accepted into the input register, the verdict for a name is formed by a
// single pass of match logic and captured in the result register, which drives the
// result channel. Only items with tlast set give a result. A result waiting on
// out_tready stalls the next last item, and the input behind it; bytes within a
// name keep flowing. os_checks is written through cfg_wr_en and cfg_wr_data and is
// used when each name ends. No clearing pass follows reset.
module filename_sanity_checker
  import fsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_byte
  input  logic       in_tuser,   // has_byte
  input  logic       in_tlast,   // last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // sane, reject_reason[2:0], zero pad
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    pop;
  logic    os_r, os_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t verdict;

  assign in_item.char_byte = in_tdata;
  assign in_item.has_byte  = in_tuser;
  assign in_item.last      = in_tlast;

  assign pop = stage_valid && (!stage_item.last || !out_valid_r || out_tready);

  fsc_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (in_item),
    .pop         (pop),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  fsc_name_scan u_name_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (pop),
    .item      (stage_item),
    .os_checks (os_r),
    .verdict   (verdict)
  );

  always_comb begin
    os_nxt = cfg_wr_en ? cfg_wr_data : os_r;
    out_valid_nxt = out_valid_r;
    if (pop && stage_item.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      os_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      os_r        <= os_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && stage_item.last) begin
      out_res_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r.reject_reason, out_res_r.sane};

`ifndef SYNTHESIS
  a_sane_matches_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.sane == (out_res_r.reject_reason == RSN_OK)))
    else $error("sane flag disagrees with reason");

  a_os_reasons_need_os: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !os_r) |->
      (out_res_r.reject_reason != RSN_RESERVED &&
       out_res_r.reject_reason != RSN_FORBIDDEN))
    else $error("os reason reported with os checks off");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && stage_item.last) |=> out_valid_r)
    else $error("last item gave no result");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (stage_valid && stage_item.last && out_valid_r && !out_tready))
    else $error("input stalled without a waiting result");
`endif

endmodule

// File: bench/filename_sanity_checker_tb.sv
// testbench for the filename sanity checker: streams file names through the block
// and compares every verdict with a byte-by-byte model of the naming rules
// depends on fsc_pkg and filename_sanity_checker
module filename_sanity_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsc_pkg::*;

  typedef logic [7:0] name_bytes_t[$];

  localparam int NUM_NAMES   = 22;
  localparam int PHASE_ITEMS = 205;
  localparam int NUM_PHASES  = 8;
  localparam int HOLD_LEN    = 300;
  localparam int STUCK_LIMIT = 3000;
  localparam int SETTLE      = 6;
  localparam logic [7:0] ASCII_DOT   = 8'h2e;
  localparam logic [7:0] ASCII_SLASH = 8'h2f;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // char_byte
  logic       in_tuser = 1'b0;    // has_byte
  logic       in_tlast = 1'b0;    // last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // sane, reject_reason[2:0], zero pad
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  function automatic int res_size(int idx);
    return (idx < 4) ? 3 : 4;
  endfunction

  function automatic logic [7:0] res_char(int idx, int p);
    string base = "CONPRNAUXNUL";
    string com = "COM";
    string lpt = "LPT";
    if (idx < 4) return base[idx * 3 + p];
    if (idx < 13) return (p < 3) ? com[p] : 8'(8'h30 + idx - 3);
    return (p < 3) ? lpt[p] : 8'(8'h30 + idx - 12);
  endfunction

  function automatic bit blocked(logic [7:0] b);
    return (b <= 8'd31) ||
           (b inside {8'h3c, 8'h3e, 8'h3a, 8'h22, 8'h7c, 8'h3f, 8'h2a, 8'h5c});
  endfunction

  typedef struct {
    bit      sane;
    reason_t why;
  } verdict_t;

  class name_checker;
    bit          os_on;
    int          errors;
    logic [2:0]  pos;
    logic [21:0] cand;
    logic [1:0]  rstate;
    logic [1:0]  dots;
    bit          slash;
    bit          bad;
    verdict_t    verdicts[$];

    function new();
      os_on = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos = 3'd0;
      cand = '1;
      rstate = 2'd0;
      dots = 2'd0;
      slash = 1'b0;
      bad = 1'b0;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void take(logic [7:0] b);
      logic [7:0] up;
      bit dot_after;
      up = (b >= 8'h61 && b <= 8'h7a) ? b - 8'd32 : b;
      dot_after = 1'b0;
      for (int i = 0; i < NUM_NAMES; i++) begin
        if (cand[i]) begin
          if (pos < res_size(i)) begin
            if (up != res_char(i, pos)) cand[i] = 1'b0;
          end else begin
            if (pos == res_size(i) && b == ASCII_DOT) dot_after = 1'b1;
            cand[i] = 1'b0;
          end
        end
      end
      if (rstate == 2'd1 && b == ASCII_DOT) rstate = 2'd2;
      if (dot_after) rstate = 2'd1;
      if (b == ASCII_DOT && dots < 2'd2) dots = dots + 2'd1;
      else dots = 2'd3;
      if (b == ASCII_SLASH) slash = 1'b1;
      else if (blocked(b) && !slash) bad = 1'b1;
      if (pos < 3'd5) pos = pos + 3'd1;
    endfunction

    function bit reserved_match();
      if (rstate == 2'd1) return 1'b1;
      for (int i = 0; i < NUM_NAMES; i++)
        if (cand[i] && res_size(i) == pos) return 1'b1;
      return 1'b0;
    endfunction

    function void note_item(logic [7:0] b, logic has, logic last);
      verdict_t v;
      if (has) take(b);
      if (!last) return;
      if (dots == 2'd1 || dots == 2'd2) v.why = RSN_DOT;
      else if (os_on && reserved_match()) v.why = RSN_RESERVED;
      else if (os_on && bad) v.why = RSN_FORBIDDEN;
      else if (slash) v.why = RSN_SLASH;
      else v.why = RSN_OK;
      v.sane = (v.why == RSN_OK);
      verdicts.push_back(v);
      clear();
    endfunction

    function void check_result(logic [7:0] d);
      verdict_t v;
      if (verdicts.size() == 0) begin
        errors++;
        $display("%0t unexpected result: actual sane=%0d reason=%0d pad=%0h",
                 $time, d[0], d[3:1], d[7:4]);
        return;
      end
      v = verdicts.pop_front();
      if (d[0] !== v.sane || d[3:1] !== v.why || d[7:4] !== 4'h0) begin
        errors++;
        $display("%0t verdict mismatch: expected sane=%0d reason=%0d pad=0,",
                 $time, v.sane, v.why);
        $display("%0t   actual sane=%0d reason=%0d pad=%0h",
                 $time, d[0], d[3:1], d[7:4]);
      end
    endfunction
  endclass

  name_checker sb = new();

  filename_sanity_checker dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // result side: check, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] mixed_case(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5a && $urandom_range(1) == 1) return c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] pick_byte();
    string punct = "<>:\"|?*\\";
    string alnum = "abcxyzCOMLPTNULAUXPRN019";
    case ($urandom_range(9))
      0, 1, 2, 3: return alnum[$urandom_range(alnum.len() - 1)];
      4: return ASCII_DOT;
      5: return ASCII_SLASH;
      6: return punct[$urandom_range(punct.len() - 1)];
      7: return 8'($urandom_range(31));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic name_bytes_t random_name();
    name_bytes_t q;
    int idx;
    int n;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        idx = $urandom_range(NUM_NAMES - 1);
        for (int p = 0; p < res_size(idx); p++) q.push_back(mixed_case(res_char(idx, p)));
        case ($urandom_range(5))
          1: q.push_back(ASCII_DOT);
          2, 3: begin
            q.push_back(ASCII_DOT);
            n = $urandom_range(3);
            repeat (n) q.push_back(pick_byte());
          end
          4: q.push_back(pick_byte());
          5: void'(q.pop_back());
          default: ;
        endcase
      end
      4: begin
        n = $urandom_range(1, 4);
        repeat (n) q.push_back(ASCII_DOT);
        if ($urandom_range(2) == 0) q.push_back(pick_byte());
      end
      5: ;
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) q.push_back(pick_byte());
      end
    endcase
    return q;
  endfunction

  function automatic name_bytes_t text(string s);
    name_bytes_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_item(logic [7:0] b, logic has, logic last, bit counted);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= has;
    in_tlast <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_item(b, has, last);
    if (counted) items_sent++;
  endtask

  task automatic send_name(name_bytes_t q, bit split_end, bit noisy);
    bit sep;
    sep = split_end || (q.size() == 0);
    foreach (q[i]) begin
      if (noisy && $urandom_range(99) < 5) send_item(8'($urandom), 1'b0, 1'b0, 1'b0);
      send_item(q[i], 1'b1, !sep && (i == q.size() - 1), 1'b1);
    end
    if (sep) send_item(8'($urandom), 1'b0, 1'b1, 1'b1);
  endtask

  task automatic write_os_checks(logic v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.os_on = v;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idle(int mode);
    case (mode)
      1: begin sender_idle_pct = 45; recv_stall_pct <= 0; end
      2: begin sender_idle_pct = 0;  recv_stall_pct <= 45; end
      3: begin sender_idle_pct = 37; recv_stall_pct <= 37; end
      default: begin sender_idle_pct = 0; recv_stall_pct <= 0; end
    endcase
  endtask

  initial begin
    int base;
    bit paused;
    paused = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_os_checks(1'b1);
    send_name(text(""), 1'b1, 1'b0);
    send_name(text("."), 1'b0, 1'b0);
    send_name(text(".."), 1'b0, 1'b0);
    send_name(text("..."), 1'b0, 1'b0);
    send_name(text("cOn"), 1'b0, 1'b0);
    send_name(text("LpT9.x"), 1'b0, 1'b0);
    send_name(text("a/<"), 1'b0, 1'b0);
    // zero and top byte, a byteless item mid-name, byteless end
    send_item(8'h00, 1'b1, 1'b0, 1'b1);
    send_item(8'h5a, 1'b0, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b0, 1'b1);
    send_item(8'ha5, 1'b0, 1'b1, 1'b1);
    settle();
    base = items_sent;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_os_checks(ph >= NUM_PHASES / 2);
      set_idle(ph % 4);
      if (ph == 1) hold_req <= hold_req + 1;
      while (items_sent < base + (ph + 1) * PHASE_ITEMS) begin
        if (ph == 2 && !paused && items_sent >= base + 2 * PHASE_ITEMS + PHASE_ITEMS / 2) begin
          paused = 1'b1;
          in_tvalid <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_name(random_name(), $urandom_range(99) < 12, 1'b1);
      end
      settle();
    end

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
